[sv/otsu_pkg.sv]
// Shared types, constants and control structs for the tile Otsu threshold block
package otsu_pkg;
    localparam int MAX_TILE_PIXELS = 4096;
    localparam int CNT_W = $clog2(MAX_TILE_PIXELS + 1);
    localparam int NUM_BINS = 256;
    localparam int BIN_W = 8;
    localparam int CONTRAST_BAND = 20;
    localparam int CONTRAST_DIV = 4000;
    localparam int DIV_W = $clog2(CONTRAST_DIV);
    localparam int SUM_W = CNT_W + BIN_W;
    localparam int PROD_W = 2 * CNT_W + BIN_W;
    localparam int D2_W = 2 * PROD_W;
    localparam int Q_W = 2 * CNT_W;
    localparam int PART_W = PROD_W + Q_W;
    localparam int CMP_W = D2_W + Q_W;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] threshold;
        logic       low_contrast;
        logic       tile_overflow;
    } out_item_t;

    typedef struct packed {
        logic acc_pixel;
        logic clr_step;
        logic tot_step;
        logic sw_start;
        logic sw_step;
        logic sw_mul1;
        logic sw_mul2;
        logic sw_cmp;
        logic sw_cmp2;
        logic band_step;
        logic finish;
        logic [BIN_W-1:0] addr;
    } dp_cmd_t;

    typedef struct packed {
        logic sw_done;
        logic skip;
    } dp_stat_t;
endpackage

[sv/otsu_datapath.sv]
// Histogram memory, tile counters, Otsu sweep and contrast count
module otsu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  otsu_pkg::dp_cmd_t  cmd,
    output otsu_pkg::dp_stat_t stat,
    output otsu_pkg::out_item_t result
);
    import otsu_pkg::*;

    logic [CNT_W-1:0] hist_mem [NUM_BINS];
    logic [CNT_W-1:0] rd_data_reg;
    logic [BIN_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             wr_en;

    logic [CNT_W-1:0] pix_cnt_reg;
    logic [DIV_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0] quot_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] total_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] wb_reg;
    logic [SUM_W-1:0] sumb_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [PROD_W-1:0] d_reg;
    logic [Q_W-1:0]    q_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [PART_W-1:0] lhs_lo_reg, rhs_lo_reg;
    logic [CMP_W-1:0]  lhs_reg, rhs_reg;
    logic [D2_W-1:0]   best_d2_reg;
    logic [Q_W-1:0]    best_q_reg;
    logic [BIN_W-1:0]  thr_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  outside_reg;
    logic [BIN_W-1:0]  rd_addr_d_reg;
    logic              cmp_pend_reg;

    logic [CNT_W-1:0] wb_next;
    logic [SUM_W-1:0] sumb_next;
    logic [PROD_W-1:0] a_val, b_val;
    logic [PROD_W-1:0] d2_part, best_d2_part;
    logic [PART_W-1:0] lhs_part, rhs_part;
    logic              full;
    logic              low_c;

    assign full = (pix_cnt_reg == CNT_W'(MAX_TILE_PIXELS));

    // histogram write: increment on pixel (read-modify-write), clear on the clear pass
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_d_reg;
        wr_data = '0;
        if (cmd.acc_pixel && !full)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg + CNT_W'(1);
        end
        else if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = cmd.addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= wr_data;
        rd_data_reg <= hist_mem[cmd.addr];
    end

    assign wb_next   = wb_reg + rd_data_reg;
    assign sumb_next = sumb_reg + SUM_W'(rd_data_reg) * SUM_W'(rd_addr_d_reg);
    assign a_val = PROD_W'(sumb_reg) * PROD_W'(total_reg);
    assign b_val = PROD_W'(sum_reg) * PROD_W'(wb_reg);

    // cross products in two halves: low half on sw_cmp, high half on sw_cmp2
    assign d2_part      = cmd.sw_cmp2 ? d2_reg[D2_W-1:PROD_W] : d2_reg[PROD_W-1:0];
    assign best_d2_part = cmd.sw_cmp2 ? best_d2_reg[D2_W-1:PROD_W] : best_d2_reg[PROD_W-1:0];
    assign lhs_part = PART_W'(d2_part) * PART_W'(best_q_reg);
    assign rhs_part = PART_W'(best_d2_part) * PART_W'(q_reg);

    assign low_c = (outside_reg <= quot_reg);

    assign stat.skip    = (wb_next == '0);
    assign stat.sw_done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
            div_cnt_reg <= '0;
            quot_reg    <= '0;
            ovf_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.acc_pixel)
            begin
                if (full)
                    ovf_reg <= 1'b1;
                else
                begin
                    pix_cnt_reg <= pix_cnt_reg + CNT_W'(1);
                    // running quotient of the pixel count by CONTRAST_DIV
                    if (div_cnt_reg == DIV_W'(CONTRAST_DIV - 1))
                    begin
                        div_cnt_reg <= '0;
                        quot_reg    <= quot_reg + CNT_W'(1);
                    end
                    else
                        div_cnt_reg <= div_cnt_reg + DIV_W'(1);
                end
            end
            if (cmd.finish)
            begin
                pix_cnt_reg <= '0;
                div_cnt_reg <= '0;
                quot_reg    <= '0;
                ovf_reg     <= 1'b0;
            end
            if (cmd.sw_start)
                done_reg <= 1'b0;
            else if (cmd.sw_step && !stat.skip && (total_reg == wb_next))
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_d_reg <= cmd.addr;
        if (cmd.clr_step)
        begin
            total_reg <= '0;
            sum_reg   <= '0;
        end
        if (cmd.tot_step)
        begin
            total_reg <= total_reg + rd_data_reg;
            sum_reg   <= sum_reg + SUM_W'(rd_data_reg) * SUM_W'(rd_addr_d_reg);
        end
        if (cmd.sw_start)
        begin
            wb_reg      <= '0;
            sumb_reg    <= '0;
            best_d2_reg <= '0;
            best_q_reg  <= Q_W'(1);
            thr_reg     <= '0;
            outside_reg <= '0;
        end
        if (cmd.sw_step)
        begin
            wb_reg   <= wb_next;
            sumb_reg <= sumb_next;
            bin_reg  <= rd_addr_d_reg;
        end
        if (cmd.sw_mul1)
        begin
            d_reg <= (a_val > b_val) ? a_val - b_val : b_val - a_val;
            q_reg <= Q_W'(wb_reg) * Q_W'(total_reg - wb_reg);
        end
        if (cmd.sw_mul2)
            d2_reg <= D2_W'(d_reg) * D2_W'(d_reg);
        if (cmd.sw_cmp)
        begin
            lhs_lo_reg <= lhs_part;
            rhs_lo_reg <= rhs_part;
        end
        if (cmd.sw_cmp2)
        begin
            lhs_reg <= CMP_W'(lhs_lo_reg) + {lhs_part, {PROD_W{1'b0}}};
            rhs_reg <= CMP_W'(rhs_lo_reg) + {rhs_part, {PROD_W{1'b0}}};
        end
        if (cmd.band_step)
        begin
            if ((10'(rd_addr_d_reg) > 10'(thr_reg) + 10'(CONTRAST_BAND))
                || (10'(rd_addr_d_reg) + 10'(CONTRAST_BAND) < 10'(thr_reg)))
                outside_reg <= outside_reg + rd_data_reg;
        end
        if (cmd.finish)
        begin
            result.threshold     <= low_c ? '0 : thr_reg;
            result.low_contrast  <= low_c;
            result.tile_overflow <= ovf_reg;
        end
        // a compare result lands in the cycle after sw_cmp2
        if (cmp_pend_reg && (lhs_reg > rhs_reg))
        begin
            best_d2_reg <= d2_reg;
            best_q_reg  <= q_reg;
            thr_reg     <= bin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_pend_reg <= 1'b0;
        else
            cmp_pend_reg <= cmd.sw_cmp2;
    end
endmodule

[sv/otsu_ctrl.sv]
// Sequencer for pixel accumulate, total pass, sweep, band count and clear
module otsu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  otsu_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    input  otsu_pkg::dp_stat_t stat,
    output otsu_pkg::dp_cmd_t  cmd
);
    import otsu_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_ACC   = 11'b00000000100,
        S_TOT   = 11'b00000001000,
        S_SWRD  = 11'b00000010000,
        S_M1    = 11'b00000100000,
        S_M2    = 11'b00001000000,
        S_CMP   = 11'b00010000000,
        S_CMP2  = 11'b00100000000,
        S_BAND  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [BIN_W:0] idx_reg, idx_next;
    logic last_reg, last_next;
    logic [2:0] wait_reg, wait_next;
    logic ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        wait_next  = wait_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.addr   = idx_reg[BIN_W-1:0];
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                idx_next = idx_reg + (BIN_W+1)'(1);
                if (idx_reg[BIN_W-1:0] == '1)
                begin
                    state_next = S_IDLE;
                    idx_next = '0;
                end
            end
            S_IDLE:
            begin
                cmd.addr = in_item.pixel;
                if (in_valid)
                begin
                    last_next  = in_item.last;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc_pixel = 1'b1;
                cmd.addr = '0;
                idx_next = '0;
                state_next = last_reg ? S_TOT : S_IDLE;
            end
            S_TOT:
            begin
                // read addr idx, accumulate previous read
                cmd.addr = idx_reg[BIN_W-1:0];
                cmd.tot_step = (idx_reg != '0);
                idx_next = idx_reg + (BIN_W+1)'(1);
                if (idx_reg == (BIN_W+1)'(NUM_BINS))
                begin
                    cmd.sw_start = 1'b1;
                    cmd.addr = '0;
                    idx_next = (BIN_W+1)'(1);
                    wait_next = '0;
                    state_next = S_SWRD;
                end
            end
            S_SWRD:
            begin
                // data for idx-1 is on the read register
                if (wait_reg == 3'd0)
                begin
                    cmd.addr = idx_reg[BIN_W-1:0] - BIN_W'(1);
                    wait_next = 3'd1;
                end
                else if (stat.sw_done || idx_reg == (BIN_W+1)'(NUM_BINS+1))
                begin
                    cmd.sw_start = 1'b0;
                    idx_next = '0;
                    cmd.addr = '0;
                    state_next = S_BAND;
                end
                else
                begin
                    cmd.sw_step = 1'b1;
                    if (stat.skip || (stat.sw_done))
                    begin
                        idx_next = idx_reg + (BIN_W+1)'(1);
                        cmd.addr = idx_reg[BIN_W-1:0];
                        wait_next = 3'd0;
                    end
                    else
                        state_next = S_M1;
                end
            end
            S_M1:
            begin
                cmd.sw_mul1 = 1'b1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.sw_mul2 = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // with wf==0 both sides are zero, so the compare never wins
                cmd.sw_cmp = 1'b1;
                state_next = S_CMP2;
            end
            S_CMP2:
            begin
                cmd.sw_cmp2 = 1'b1;
                cmd.addr = idx_reg[BIN_W-1:0];
                idx_next = idx_reg + (BIN_W+1)'(1);
                wait_next = 3'd0;
                state_next = S_SWRD;
            end
            S_BAND:
            begin
                cmd.addr = idx_reg[BIN_W-1:0];
                cmd.band_step = (idx_reg != '0);
                idx_next = idx_reg + (BIN_W+1)'(1);
                if (idx_reg == (BIN_W+1)'(NUM_BINS))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.finish = 1'b1;
                    ov_next = 1'b1;
                    idx_next = '0;
                    state_next = S_CLEAR;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            wait_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            wait_reg  <= wait_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

[sv/tile_otsu_threshold.sv]
// Top level: Otsu threshold per tile of 8-bit grey pixels
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one pixel and a last mark.
//   out channel (out_valid/out_ready/out_data) carries one result per tile:
//   threshold, low_contrast flag and tile_overflow flag.
//   A pixel request is a histogram read-modify-write (read, then write back
//   plus one); no further pixel is accepted until it is done. After the last
//   pixel: a totals pass, a sweep over the bins (read, two multiply stages
//   and a compare in two halves on bins with a nonempty background), a
//   contrast band pass, then the result is registered. A clear of all bins
//   follows each tile and also runs after reset; no pixel is accepted during it.
//   Pixels past 4096 in a tile are dropped and flagged.
//   If the receiver stalls, the result holds; the clear pass still runs and
//   the next tile's pixels are taken, but that tile's result waits in the
//   output stage and no further pixel is accepted until the first is taken.
module tile_otsu_threshold (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  otsu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output otsu_pkg::out_item_t out_data
);
    import otsu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     rdy;

    assign in_ready = rdy;

    otsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (rdy),
        .in_item   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    otsu_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );
endmodule

[sv/otsu_checker.sv]
// Port-level checker for the tile Otsu threshold block, with its bind
module otsu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input otsu_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input otsu_pkg::out_item_t out_data
);
    import otsu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.low_contrast |-> out_data.threshold == '0)
        else $error("low contrast result with nonzero threshold");

    a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second pixel taken in next cycle");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind tile_otsu_threshold otsu_checker u_otsu_checker (.*);

[sim/tb_tile_otsu_threshold.sv]
// Testbench for tile_otsu_threshold: pixel tiles in, per-tile Otsu thresholds and flags checked
`timescale 1ns / 100ps

module tb_tile_otsu_threshold;
    import otsu_pkg::*;

    typedef enum int { TILE_UNIFORM, TILE_BIMODAL, TILE_NARROW, TILE_FLAT } tile_shape_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    tile_otsu_threshold dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predictor state
    int unsigned hist[NUM_BINS];
    int unsigned tile_pixels;
    bit          tile_dropped;
    out_item_t   thr_queue[$];

    int unsigned errors;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned in_idle_pct;
    int unsigned out_stall_pct;
    int unsigned hold_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] otsu_split();
        logic [127:0] total, sum, wb, wf, sumb, a, b, d, q, d2, best_d2, best_q;
        logic [7:0]   thr;
        total = 0;
        sum = 0;
        wb = 0;
        sumb = 0;
        best_d2 = 0;
        best_q = 1;
        thr = 0;
        for (int t = 0; t < NUM_BINS; t++)
        begin
            total += hist[t];
            sum += 128'(t) * hist[t];
        end
        for (int t = 0; t < NUM_BINS; t++)
        begin
            wb += hist[t];
            if (wb == 0)
                continue;
            wf = total - wb;
            if (wf == 0)
                break;
            sumb += 128'(t) * hist[t];
            a = sumb * total;
            b = sum * wb;
            d = (a > b) ? a - b : b - a;
            q = wb * wf;
            d2 = d * d;
            // strict cross-multiplied compare, ties keep the earlier bin
            if (d2 * best_q > best_d2 * q)
            begin
                best_d2 = d2;
                best_q = q;
                thr = t[7:0];
            end
        end
        return thr;
    endfunction

    function automatic void predict_pixel(in_item_t item);
        out_item_t   res;
        logic [7:0]  thr;
        int unsigned outside;
        if (tile_pixels >= MAX_TILE_PIXELS)
            tile_dropped = 1'b1;
        else
        begin
            hist[item.pixel]++;
            tile_pixels++;
        end
        if (!item.last)
            return;
        thr = otsu_split();
        outside = 0;
        for (int v = 0; v < NUM_BINS; v++)
            if (v > int'(thr) + CONTRAST_BAND || v < int'(thr) - CONTRAST_BAND)
                outside += hist[v];
        res.low_contrast = (outside <= tile_pixels / CONTRAST_DIV);
        res.threshold = res.low_contrast ? 8'd0 : thr;
        res.tile_overflow = tile_dropped;
        thr_queue.push_back(res);
        foreach (hist[i])
            hist[i] = 0;
        tile_pixels = 0;
        tile_dropped = 1'b0;
    endfunction

    // accept monitor and result checker
    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && in_valid && in_ready)
            predict_pixel(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (thr_queue.size() == 0)
            begin
                $error("unexpected result threshold=%0d", out_data.threshold);
                errors++;
            end
            else
            begin
                exp_res = thr_queue.pop_front();
                if (out_data.threshold !== exp_res.threshold)
                begin
                    $error("threshold: expected %0d, got %0d", exp_res.threshold,
                           out_data.threshold);
                    errors++;
                end
                if (out_data.low_contrast !== exp_res.low_contrast)
                begin
                    $error("low_contrast: expected %0b, got %0b", exp_res.low_contrast,
                           out_data.low_contrast);
                    errors++;
                end
                if (out_data.tile_overflow !== exp_res.tile_overflow)
                begin
                    $error("tile_overflow: expected %0b, got %0b", exp_res.tile_overflow,
                           out_data.tile_overflow);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall, plus a counted long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= out_stall_pct);
    end

    task automatic send_pixel(input logic [7:0] pix, input logic last);
        while ($urandom_range(99) < in_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_data.pixel = pix;
        in_data.last = last;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        @(negedge clk);
        in_valid = 1'b0;
        in_data = '0;
    endtask

    task automatic send_tile(input int unsigned len, input tile_shape_t shape);
        logic [7:0] base;
        logic [7:0] lo_lvl;
        logic [7:0] hi_lvl;
        logic [7:0] pix;
        base = 8'($urandom_range(255));
        lo_lvl = 8'($urandom_range(127));
        hi_lvl = 8'($urandom_range(255, 128));
        for (int unsigned i = 0; i < len; i++)
        begin
            case (shape)
                TILE_UNIFORM: pix = 8'($urandom_range(255));
                TILE_BIMODAL: pix = $urandom_range(1) ? 8'(lo_lvl + $urandom_range(3))
                                                      : 8'(hi_lvl - $urandom_range(3));
                TILE_NARROW:  pix = 8'(base + $urandom_range(12));
                default:      pix = base;
            endcase
            send_pixel(pix, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (thr_queue.size() != 0)
            @(negedge clk);
        // block may still be clearing after a tile
        repeat (600) @(negedge clk);
    endtask

    task automatic test_directed();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd110, 1'b0);
        send_pixel(8'd121, 1'b1);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd20, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd210, 1'b1);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int unsigned idle, input int unsigned stall,
                               input int unsigned n_tiles);
        in_idle_pct = idle;
        out_stall_pct = stall;
        for (int unsigned k = 0; k < n_tiles; k++)
            send_tile($urandom_range(1, 20), tile_shape_t'($urandom_range(3)));
        wait_drained();
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        out_stall_pct = 0;
        @(negedge clk);
        hold_cycles = 8000;
        for (int unsigned k = 0; k < 4; k++)
            send_tile($urandom_range(2, 6), TILE_BIMODAL);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        hold_cycles = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        tile_pixels = 0;
        tile_dropped = 1'b0;
        foreach (hist[i])
            hist[i] = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(0, 0, 15);
        test_random(47, 0, 12);
        test_random(0, 47, 12);
        test_random(14, 14, 12);
        test_backpressure();

        $display("Run covered %0d pixel requests and %0d tile results,", requests_sent,
                 results_seen);
        $display("with idle/stall phases and a long output hold that backs up the input.");
        if (errors == 0 && thr_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

[filelist.f]
sv/otsu_pkg.sv
sv/otsu_datapath.sv
sv/otsu_ctrl.sv
sv/tile_otsu_threshold.sv
sv/otsu_checker.sv
sim/tb_tile_otsu_threshold.sv
